### rtl/core/phxc_pkg.sv
// ----------------------------------------------------------------------------
// phxc_pkg
// Shared types, constants and helpers for the packet header xor checker.
// ----------------------------------------------------------------------------
package phxc_pkg;

  localparam int WORD_W    = 32;
  localparam int IDX_W     = 10;
  localparam int MAX_WORDS = 512;
  localparam int CFG_IDX_W = 3;
  localparam int MIN_WORDS = 4;

  localparam logic [WORD_W-1:0] HI_BYTE_MASK = 32'hFF00FF00;
  localparam logic [WORD_W-1:0] LO_BYTE_MASK = 32'h00FF00FF;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_OK       = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_START    = 3'd3,
    ST_ID       = 3'd4,
    ST_SIZE     = 3'd5,
    ST_CHECKSUM = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_WORD       = 3'd0,
    REG_PACKET_ID        = 3'd1,
    REG_SIZE_VALUE       = 3'd2,
    REG_WORDS_PER_PACKET = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_in;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic              swapped;
    logic              end_of_packet;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] start_word;
    logic [WORD_W-1:0] packet_id;
    logic [WORD_W-1:0] size_value;
    logic [IDX_W-1:0]  words_per_packet;
  } cfg_t;

  function automatic logic [WORD_W-1:0] swap_halves(input logic [WORD_W-1:0] x);
    return ((x << 8) & HI_BYTE_MASK) | ((x >> 8) & LO_BYTE_MASK);
  endfunction

endpackage

### rtl/core/phxc_cfg.sv
// ----------------------------------------------------------------------------
// phxc_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module phxc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [phxc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [phxc_pkg::WORD_W-1:0]    cfg_data,
  output phxc_pkg::cfg_t                 cfg
);

  phxc_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_word       <= phxc_pkg::WORD_W'(2048);
      regs.packet_id        <= phxc_pkg::WORD_W'(1);
      regs.size_value       <= '0;
      regs.words_per_packet <= phxc_pkg::IDX_W'(18);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        phxc_pkg::REG_START_WORD:       regs.start_word <= cfg_data;
        phxc_pkg::REG_PACKET_ID:        regs.packet_id  <= cfg_data;
        phxc_pkg::REG_SIZE_VALUE:       regs.size_value <= cfg_data;
        phxc_pkg::REG_WORDS_PER_PACKET:
          regs.words_per_packet <= cfg_data[phxc_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/packet_header_xor_checker.sv
// ----------------------------------------------------------------------------
// packet_header_xor_checker
// Per-word header check, byte order detection and xor checksum of packets.
// ----------------------------------------------------------------------------
// One word is taken per cycle unless the output stalls; its result appears in
// the output register on the next cycle and stays there until taken, while a
// new word may enter in the same cycle the old result leaves. That rate is set
// by the single compare/xor step in front of the result register. Word 0 picks
// the byte order of the packet, words 1 and 2 are checked against the id and
// size registers, and the last word carries the status. Configuration must be
// written only between packets; the block itself does not enforce this.
module packet_header_xor_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  phxc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output phxc_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [phxc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [phxc_pkg::WORD_W-1:0]    cfg_data
);

  phxc_pkg::cfg_t cfg;

  logic [phxc_pkg::IDX_W-1:0]  word_index, word_index_next;
  logic [phxc_pkg::WORD_W-1:0] xor_sum, xor_sum_next;
  logic                        swap_mode, swap_mode_next;
  phxc_pkg::status_t           header_error, header_error_next;
  phxc_pkg::out_item_t         result_next;

  logic                        accept;
  logic                        first;
  logic                        swap_now;
  logic [phxc_pkg::WORD_W-1:0] conv;
  logic [phxc_pkg::IDX_W:0]    count;
  logic                        len_ok;

  phxc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    first    = (word_index == '0);
    swap_now = first ? (in_data.word_in == phxc_pkg::swap_halves(cfg.start_word))
                     : swap_mode;
    conv     = swap_now ? phxc_pkg::swap_halves(in_data.word_in) : in_data.word_in;

    header_error_next = header_error;
    if (header_error == phxc_pkg::ST_PENDING) begin
      if (first && conv != cfg.start_word) begin
        header_error_next = phxc_pkg::ST_START;
      end else if (word_index == phxc_pkg::IDX_W'(1) && conv != cfg.packet_id) begin
        header_error_next = phxc_pkg::ST_ID;
      end else if (word_index == phxc_pkg::IDX_W'(2) && conv != cfg.size_value) begin
        header_error_next = phxc_pkg::ST_SIZE;
      end
    end

    count  = {1'b0, word_index} + (phxc_pkg::IDX_W+1)'(1);
    len_ok = cfg.words_per_packet >= phxc_pkg::IDX_W'(phxc_pkg::MIN_WORDS) &&
             {1'b0, cfg.words_per_packet} <= (phxc_pkg::IDX_W+1)'(phxc_pkg::MAX_WORDS) &&
             count == {1'b0, cfg.words_per_packet};

    result_next.word_out      = conv;
    result_next.swapped       = swap_now;
    result_next.end_of_packet = in_data.last_in;
    result_next.status        = phxc_pkg::ST_PENDING;

    if (in_data.last_in) begin
      if (!len_ok) begin
        result_next.status = phxc_pkg::ST_LENGTH;
      end else if (header_error_next != phxc_pkg::ST_PENDING) begin
        result_next.status = header_error_next;
      end else if (xor_sum != conv) begin
        result_next.status = phxc_pkg::ST_CHECKSUM;
      end else begin
        result_next.status = phxc_pkg::ST_OK;
      end
      word_index_next   = '0;
      xor_sum_next      = '0;
      swap_mode_next    = 1'b0;
      header_error_next = phxc_pkg::ST_PENDING;
    end else begin
      xor_sum_next    = xor_sum ^ conv;
      swap_mode_next  = swap_now;
      word_index_next = word_index;
      if ({1'b0, word_index} < (phxc_pkg::IDX_W+1)'(phxc_pkg::MAX_WORDS)) begin
        word_index_next = word_index + phxc_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index   <= '0;
      xor_sum      <= '0;
      swap_mode    <= 1'b0;
      header_error <= phxc_pkg::ST_PENDING;
    end else if (accept) begin
      word_index   <= word_index_next;
      xor_sum      <= xor_sum_next;
      swap_mode    <= swap_mode_next;
      header_error <= header_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result_next;
    end
  end

endmodule

### rtl/core/phxc_check.sv
// ----------------------------------------------------------------------------
// phxc_check
// Port-level checks of the packet header xor checker, bound to the top level.
// ----------------------------------------------------------------------------
module phxc_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input phxc_pkg::out_item_t out_data
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // status only on the last word
  a_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.end_of_packet |-> out_data.status == phxc_pkg::ST_PENDING)
    else $error("status on a word that is not last");

  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_packet |-> out_data.status != phxc_pkg::ST_PENDING)
    else $error("last word without a final status");

  // every accepted request shows a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind packet_header_xor_checker phxc_check u_phxc_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### sim/tb_packet_header_xor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_header_xor_checker
// Self-checking bench for the packet header / xor checksum checker. Packets
// are built from the current register settings: good ones, ones with a bad
// header word or checksum, wrong lengths and pure noise. They are sent in
// both byte orders. An in-bench model of the checker predicts every result
// word, and each result is compared field by field as it is taken.
// ----------------------------------------------------------------------------
module tb_packet_header_xor_checker;
  import phxc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_GAP     = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

  typedef enum int {
    FLT_NONE     = 0,
    FLT_START    = 1,
    FLT_ID       = 2,
    FLT_SIZE     = 3,
    FLT_ID_SIZE  = 4,
    FLT_CHECKSUM = 5,
    FLT_NOISE    = 6
  } fault_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data  = '0;

  // register copies and per-packet state of the model
  logic [WORD_W-1:0] cfg_start;
  logic [WORD_W-1:0] cfg_id;
  logic [WORD_W-1:0] cfg_size;
  logic [IDX_W-1:0]  cfg_wpp;
  logic [IDX_W-1:0]  pk_index;
  logic [WORD_W-1:0] pk_xor;
  logic              pk_swapped;
  status_t           pk_hdr_err;

  out_item_t   expected_words[$];
  int unsigned words_sent   = 0;
  int unsigned results_done = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned packets_done = 0;
  int unsigned swapped_pkts = 0;
  int unsigned longest_pkt  = 0;
  int unsigned status_hist[8];
  int          idle_in_pct  = 0;
  int          idle_out_pct = 0;

  packet_header_xor_checker uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] halfword_byte_swap(input logic [WORD_W-1:0] x);
    return {x[23:16], x[31:24], x[7:0], x[15:8]};
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results taken",
               cycles, results_done, words_sent);
      $display("tb_packet_header_xor_checker NOT OK");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= idle_out_pct);

  always @(posedge clk) begin : checker_model
    out_item_t         want;
    logic [WORD_W-1:0] conv;
    logic              len_ok;
    if (rst) begin
      cfg_start  = 32'h0000_0800;
      cfg_id     = 32'h0000_0001;
      cfg_size   = '0;
      cfg_wpp    = 10'd18;
      pk_index   = '0;
      pk_xor     = '0;
      pk_swapped = 1'b0;
      pk_hdr_err = ST_PENDING;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_done++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: word %h swapped %b eop %b status %0d",
                     out_data.word_out, out_data.swapped, out_data.end_of_packet,
                     out_data.status);
        end else begin
          want = expected_words.pop_front();
          if (out_data.word_out !== want.word_out || out_data.swapped !== want.swapped ||
              out_data.end_of_packet !== want.end_of_packet ||
              out_data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected word %h sw %b eop %b st %0d, got %h %b %b %0d",
                       results_done, want.word_out, want.swapped, want.end_of_packet,
                       want.status, out_data.word_out, out_data.swapped,
                       out_data.end_of_packet, out_data.status);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (pk_index == 0)
          pk_swapped = (in_data.word_in == halfword_byte_swap(cfg_start));
        conv = pk_swapped ? halfword_byte_swap(in_data.word_in) : in_data.word_in;
        if (pk_hdr_err == ST_PENDING) begin
          if (pk_index == 0 && conv != cfg_start)
            pk_hdr_err = ST_START;
          else if (pk_index == 1 && conv != cfg_id)
            pk_hdr_err = ST_ID;
          else if (pk_index == 2 && conv != cfg_size)
            pk_hdr_err = ST_SIZE;
        end
        want.word_out      = conv;
        want.swapped       = pk_swapped;
        want.end_of_packet = in_data.last_in;
        want.status        = ST_PENDING;
        if (in_data.last_in) begin
          len_ok = cfg_wpp >= MIN_WORDS && cfg_wpp <= MAX_WORDS &&
                   int'(pk_index) + 1 == int'(cfg_wpp);
          if (!len_ok)
            want.status = ST_LENGTH;
          else if (pk_hdr_err != ST_PENDING)
            want.status = pk_hdr_err;
          else if (pk_xor != conv)
            want.status = ST_CHECKSUM;
          else
            want.status = ST_OK;
          packets_done++;
          swapped_pkts += pk_swapped;
          status_hist[int'(want.status)]++;
          pk_index   = '0;
          pk_xor     = '0;
          pk_swapped = 1'b0;
          pk_hdr_err = ST_PENDING;
        end else begin
          pk_xor = pk_xor ^ conv;
          if (pk_index < MAX_WORDS)
            pk_index++;
        end
        expected_words.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_WORD:       cfg_start = cfg_data;
          REG_PACKET_ID:        cfg_id    = cfg_data;
          REG_SIZE_VALUE:       cfg_size  = cfg_data;
          REG_WORDS_PER_PACKET: cfg_wpp   = cfg_data[IDX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // one request per word; valid is left high so the next word can follow at once
  task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_in_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{word_in: w, last_in: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_done < words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [WORD_W-1:0] s, input logic [WORD_W-1:0] id,
                            input logic [WORD_W-1:0] sz, input logic [WORD_W-1:0] wpp);
    write_reg(REG_START_WORD, s);
    write_reg(REG_PACKET_ID, id);
    write_reg(REG_SIZE_VALUE, sz);
    write_reg(REG_WORDS_PER_PACKET, wpp);
  endtask

  // header from current settings, checksum from earlier words, then a fault is applied
  task automatic send_packet(input int len, input bit swp, input fault_t f);
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] flip;
    sum  = '0;
    flip = 32'h1 << $urandom_range(0, 31);
    if (len > longest_pkt)
      longest_pkt = len;
    for (int k = 0; k < len; k++) begin
      if (k == len - 1)
        w = sum;
      else if (k == 0)
        w = cfg_start;
      else if (k == 1)
        w = cfg_id;
      else if (k == 2)
        w = cfg_size;
      else
        w = pick_word();
      if ((k == 0 && f == FLT_START) ||
          (k == 1 && (f == FLT_ID || f == FLT_ID_SIZE)) ||
          (k == 2 && (f == FLT_SIZE || f == FLT_ID_SIZE)) ||
          (k == len - 1 && f == FLT_CHECKSUM))
        w = w ^ flip;
      if (f == FLT_NOISE)
        w = pick_word();
      if (k != len - 1)
        sum = sum ^ w;
      send_word(swp ? halfword_byte_swap(w) : w, k == len - 1);
    end
  endtask

  task automatic run_phase(input int in_pct, input int out_pct, input logic [WORD_W-1:0] s,
                           input logic [WORD_W-1:0] id, input logic [WORD_W-1:0] sz,
                           input logic [WORD_W-1:0] wpp, input int nwords);
    int unsigned target;
    int          len;
    int          r;
    fault_t      f;
    idle_in_pct  = in_pct;
    idle_out_pct = out_pct;
    set_config(s, id, sz, wpp);
    target = words_sent + nwords;
    while (words_sent < target) begin
      if ($urandom_range(0, 9) < 8)
        len = cfg_wpp;
      else
        len = $urandom_range(1, int'(cfg_wpp) + 2);
      r = $urandom_range(0, 18);
      f = (r < 13) ? FLT_NONE : fault_t'(r - 12);
      send_packet(len, $urandom_range(0, 1), f);
      if ($urandom_range(0, 11) == 0)
        wait_idle();
    end
    wait_idle();
  endtask

  task automatic test_reset_values();
    idle_in_pct  = 0;
    idle_out_pct = 0;
    send_packet(18, 1'b0, FLT_NONE);
    send_packet(18, 1'b1, FLT_NONE);
    wait_idle();
  endtask

  task automatic test_header_cases();
    // upper bits of the length write must be dropped
    set_config(32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FC04);
    send_packet(4, 1'b0, FLT_NONE);
    send_packet(4, 1'b1, FLT_NONE);
    send_packet(4, 1'b0, FLT_START);
    send_packet(4, 1'b1, FLT_ID_SIZE);
    send_packet(4, 1'b0, FLT_SIZE);
    send_packet(4, 1'b0, FLT_CHECKSUM);
    send_packet(2, 1'b0, FLT_START);
    send_packet(1, 1'b0, FLT_NONE);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 32'h0, 32'h0, 32'h0, 32'd6, 75);
    run_phase(84, 0, $urandom(), $urandom(), $urandom(), $urandom_range(4, 12), 75);
    run_phase(0, 84, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4, 75);
    run_phase(26, 26, 32'h5A5A_C3C3, $urandom(), $urandom(), $urandom_range(4, 20), 75);
  endtask

  task automatic test_register_extremes();
    logic [WORD_W-1:0] bad_len[4];
    bad_len = '{32'd0, 32'd3, 32'd513, 32'd1023};
    idle_in_pct  = 26;
    idle_out_pct = 26;
    foreach (bad_len[n]) begin
      set_config($urandom(), $urandom(), $urandom(), bad_len[n]);
      send_packet($urandom_range(1, 6), $urandom_range(0, 1), FLT_NONE);
      send_packet(4, 1'b0, FLT_NONE);
      wait_idle();
    end
    set_config($urandom(), $urandom(), $urandom(), 32'd4);
    write_reg(REG_UNUSED, $urandom());
    repeat (3) send_packet(4, $urandom_range(0, 1), FLT_NONE);
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_header_cases();
    test_random_traffic();
    test_register_extremes();
    wait_idle();
    if (expected_words.size() != 0) begin
      $display("%0d results never arrived", expected_words.size());
      mismatches += expected_words.size();
    end
    $display("covered %0d words in %0d packets, %0d in swapped byte order, lengths 1 to %0d",
             words_sent, packets_done, swapped_pkts, longest_pkt);
    $display("status seen: ok %0d length %0d start %0d id %0d size %0d checksum %0d",
             status_hist[int'(ST_OK)], status_hist[int'(ST_LENGTH)],
             status_hist[int'(ST_START)], status_hist[int'(ST_ID)],
             status_hist[int'(ST_SIZE)], status_hist[int'(ST_CHECKSUM)]);
    if (mismatches == 0) begin
      $display("tb_packet_header_xor_checker OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_packet_header_xor_checker NOT OK");
    end
    $finish;
  end

endmodule
